// File: design/uap_pkg.sv
// Shared codes of the uncertainty propagation ALU: operation kinds and status values.
package uap_pkg;

  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_SQRT = 3'd4,
    KIND_NEG  = 3'd5,
    KIND_CMP  = 3'd6
  } kind_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_NEG  = 2'd3;

endpackage

// File: design/uncertainty_propagation_alu_unit.sv
// Top level of the uncertainty propagation ALU: a fully pipelined fixed-point datapath.
// Usage:
// Each input word carries kind_i and two operands (value, uncertainty) in fixed point with
//   FRAC_BITS fractional bits; values are signed, uncertainties unsigned.
// Input channel: in_valid_i / in_ready_o. Output channel: out_valid_o / out_ready_i with
//   result_value_o, result_unc_o, is_less_o, is_equal_o and status_o.
// One result word per input word, in order.
// Throughput: one word per cycle while no result waits on a stalled receiver.
// The pipeline depth is set by three one-step-per-stage units in series: the restoring
//   divider ahead of the square root (2*WORD_BITS + FRAC_BITS steps), the square root
//   (2*WORD_BITS + FRAC_BITS steps) and the uncertainty divider behind it (WORD_BITS
//   steps).
// Reset clears every valid bit; words in flight are dropped.
// While a result waits and out_ready_i is low, all stages hold and in_ready_o is low;
//   an empty output slot lets the pipe advance, so no word is lost or repeated.
module uncertainty_propagation_alu_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  kind_i,
  input  logic signed [WORD_BITS-1:0] a_value_i,
  input  logic [WORD_BITS-1:0]        a_unc_i,
  input  logic signed [WORD_BITS-1:0] b_value_i,
  input  logic [WORD_BITS-1:0]        b_unc_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] result_value_o,
  output logic [WORD_BITS-1:0]        result_unc_o,
  output logic                        is_less_o,
  output logic                        is_equal_o,
  output logic [1:0]                  status_o
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int W2  = 2 * W;
  localparam int QW  = 4 * W;
  localparam int D1N = 2 * W + F;
  localparam int D1D = W + 2;
  localparam int D1R = D1D + 1;
  localparam int RN  = 4 * W + 2 * F;
  localparam int RK  = RN / 2;
  localparam int VN  = W + F + ((W + F) % 2);
  localparam int VK  = VN / 2;
  localparam int D2R = W2 + 1;
  localparam int CW  = (RK - W > W2) ? RK - W : W2;
  localparam int XW  = VK + W;

  localparam logic [W-1:0] MINW  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAXW = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    uap_pkg::kind_e  kind;
    logic            neg;
    logic            a_zero;
    logic            b_zero;
    logic            a_neg;
    logic            sat_e;
    logic            lt;
    logic            eq;
    logic [W-1:0]    rv_e;
    logic [W-1:0]    ua;
    logic [W2-1:0]   pv;
    logic [W2-1:0]   bb;
  } side_t;

  typedef struct packed {
    uap_pkg::kind_e kind;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [W-1:0]   ua;
    logic [W-1:0]   ub;
  } p1_t;

  typedef struct packed {
    side_t         sd;
    logic [W2-1:0] pba;
    logic [W2-1:0] pab;
    logic [W2-1:0] uu;
    logic [W2-1:0] vv;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
  } p2_t;

  typedef struct packed {
    side_t          sd;
    logic [W2-1:0]  pba;
    logic [W2-1:0]  pab;
    logic [W2:0]    addsum;
    logic [D1R-1:0] rem;
    logic [D1N-1:0] nq;
    logic [D1D-1:0] dv;
    logic [VN-1:0]  vrad;
    logic [VK+1:0]  vrem;
    logic [VK-1:0]  vroot;
  } d1_t;

  typedef struct packed {
    side_t          sd;
    logic [D1N-1:0] q1;
    logic [VK-1:0]  vroot;
    logic [W2:0]    addsum;
    logic [W2-1:0]  hh_ba;
    logic [W2-1:0]  hl_ba;
    logic [W2-1:0]  ll_ba;
    logic [W2-1:0]  hh_ab;
    logic [W2-1:0]  hl_ab;
    logic [W2-1:0]  ll_ab;
  } p3_t;

  typedef struct packed {
    side_t          sd;
    logic [D1N-1:0] q1;
    logic [VK-1:0]  vroot;
    logic [W2:0]    addsum;
    logic [QW-1:0]  sq_ba;
    logic [QW-1:0]  sq_ab;
  } p4_t;

  typedef struct packed {
    side_t          sd;
    logic [D1N-1:0] q1;
    logic [VK-1:0]  vroot;
    logic [RN-1:0]  rad;
  } p5_t;

  typedef struct packed {
    side_t          sd;
    logic [D1N-1:0] q1;
    logic [VK-1:0]  vroot;
    logic [RN-1:0]  rrad;
    logic [RK+1:0]  rrem;
    logic [RK-1:0]  rroot;
  } r_t;

  typedef struct packed {
    side_t          sd;
    logic [D1N-1:0] q1;
    logic [VK-1:0]  vroot;
    logic [RK-1:0]  root;
    logic           ovf;
    logic [D2R-1:0] rem;
    logic [W-1:0]   nq;
  } d2_t;

  function automatic logic [W:0] usat(input logic [RK-1:0] x);
    logic [W:0] r;
    if (|x[RK-1:W]) r = {1'b1, {W{1'b1}}};
    else            r = {1'b0, x[W-1:0]};
    return r;
  endfunction

  // Return {saturated, word} for a sign and a magnitude.
  function automatic logic [W:0] sgn_out(input logic neg, input logic [D1N-1:0] m);
    logic [D1N-1:0] lim;
    logic [W-1:0]   mm;
    logic           s;
    lim = neg ? D1N'(MINW) : D1N'(SMAXW);
    s   = m > lim;
    mm  = s ? lim[W-1:0] : m[W-1:0];
    return {s, neg ? (~mm + 1'b1) : mm};
  endfunction

  logic en;

  logic  p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, out_v_q;
  logic [D1N-1:0] d1_v_q;
  logic [RK-1:0]  r_v_q;
  logic [W-1:0]   d2_v_q;

  p1_t p1_q, p1_d;
  p2_t p2_q, p2_d;
  p3_t p3_q, p3_d;
  p4_t p4_q, p4_d;
  p5_t p5_q, p5_d;
  d1_t d1_q [D1N];
  d1_t d1_init;
  r_t  r_q [RK];
  r_t  r_init;
  d2_t d2_q [W];

  logic [W-1:0] rv_q, rv_d, ru_q, ru_d;
  logic         lt_q, lt_d, eq_q, eq_d;
  logic [1:0]   st_q, st_d;

  // Advance the whole pipe unless a result is waiting on a stalled receiver.
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      d1_v_q  <= '0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      r_v_q   <= '0;
      d2_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q  <= in_valid_i;
      p2_v_q  <= p1_v_q;
      d1_v_q  <= {d1_v_q[D1N-2:0], p2_v_q};
      p3_v_q  <= d1_v_q[D1N-1];
      p4_v_q  <= p3_v_q;
      p5_v_q  <= p4_v_q;
      r_v_q   <= {r_v_q[RK-2:0], p5_v_q};
      d2_v_q  <= {d2_v_q[W-2:0], r_v_q[RK-1]};
      out_v_q <= d2_v_q[W-1];
    end
  end

  // Input stage: operand magnitudes.
  always_comb begin
    p1_d.kind = uap_pkg::kind_e'(kind_i);
    p1_d.a    = a_value_i;
    p1_d.b    = b_value_i;
    p1_d.ma   = a_value_i[W-1] ? (~a_value_i + 1'b1) : a_value_i;
    p1_d.mb   = b_value_i[W-1] ? (~b_value_i + 1'b1) : b_value_i;
    p1_d.ua   = a_unc_i;
    p1_d.ub   = b_unc_i;
  end

  // Products and the value results of add, sub, negate and compare.
  logic [W:0] sum_add, sum_sub;
  always_comb begin
    sum_add = {p1_q.a[W-1], p1_q.a} + {p1_q.b[W-1], p1_q.b};
    sum_sub = {p1_q.a[W-1], p1_q.a} - {p1_q.b[W-1], p1_q.b};
    p2_d.sd.kind   = p1_q.kind;
    p2_d.sd.neg    = p1_q.a[W-1] ^ p1_q.b[W-1];
    p2_d.sd.a_zero = p1_q.a == '0;
    p2_d.sd.b_zero = p1_q.b == '0;
    p2_d.sd.a_neg  = p1_q.a[W-1];
    p2_d.sd.lt     = 1'b0;
    p2_d.sd.eq     = 1'b0;
    p2_d.sd.rv_e   = '0;
    p2_d.sd.sat_e  = 1'b0;
    p2_d.sd.ua     = p1_q.ua;
    p2_d.sd.pv     = W2'(p1_q.ma) * W2'(p1_q.mb);
    p2_d.sd.bb     = W2'(p1_q.mb) * W2'(p1_q.mb);
    case (p1_q.kind)
      uap_pkg::KIND_ADD: begin
        p2_d.sd.sat_e = sum_add[W] ^ sum_add[W-1];
        p2_d.sd.rv_e  = p2_d.sd.sat_e ? (sum_add[W] ? MINW : SMAXW) : sum_add[W-1:0];
      end
      uap_pkg::KIND_SUB: begin
        p2_d.sd.sat_e = sum_sub[W] ^ sum_sub[W-1];
        p2_d.sd.rv_e  = p2_d.sd.sat_e ? (sum_sub[W] ? MINW : SMAXW) : sum_sub[W-1:0];
      end
      uap_pkg::KIND_NEG: begin
        p2_d.sd.sat_e = p1_q.a == MINW;
        p2_d.sd.rv_e  = p2_d.sd.sat_e ? SMAXW : (~p1_q.a + 1'b1);
      end
      uap_pkg::KIND_CMP: begin
        p2_d.sd.lt = $signed(p1_q.a) < $signed(p1_q.b);
        p2_d.sd.eq = p1_q.a == p1_q.b;
      end
      default: ;
    endcase
    p2_d.pba = W2'(p1_q.mb) * W2'(p1_q.ua);
    p2_d.pab = W2'(p1_q.ma) * W2'(p1_q.ub);
    p2_d.uu  = W2'(p1_q.ua) * W2'(p1_q.ua);
    p2_d.vv  = W2'(p1_q.ub) * W2'(p1_q.ub);
    p2_d.ma  = p1_q.ma;
    p2_d.mb  = p1_q.mb;
  end

  // Load the pre-root divider: a/b for divide, ua^2/(4a) for square root.
  always_comb begin
    d1_init.sd     = p2_q.sd;
    d1_init.pba    = p2_q.pba;
    d1_init.pab    = p2_q.pab;
    d1_init.addsum = {1'b0, p2_q.uu} + {1'b0, p2_q.vv};
    d1_init.rem    = '0;
    if (p2_q.sd.kind == uap_pkg::KIND_SQRT) begin
      d1_init.nq = {p2_q.uu, {F{1'b0}}};
      d1_init.dv = {p2_q.ma, 2'b00};
    end else begin
      d1_init.nq = D1N'({p2_q.ma, {F{1'b0}}});
      d1_init.dv = D1D'(p2_q.mb);
    end
    d1_init.vrad  = VN'({p2_q.ma, {F{1'b0}}});
    d1_init.vrem  = '0;
    d1_init.vroot = '0;
  end

  genvar i;
  generate
    for (i = 0; i < D1N; i++) begin : g_d1
      d1_t            cur, nxt;
      logic [D1R-1:0] sh;
      logic [VK+1:0]  vsh, vtr;
      if (i == 0) begin : g_first
        assign cur = d1_init;
      end else begin : g_next
        assign cur = d1_q[i-1];
      end
      always_comb begin
        nxt = cur;
        sh  = {cur.rem[D1R-2:0], cur.nq[D1N-1]};
        if (sh >= {1'b0, cur.dv}) begin
          nxt.rem = sh - {1'b0, cur.dv};
          nxt.nq  = {cur.nq[D1N-2:0], 1'b1};
        end else begin
          nxt.rem = sh;
          nxt.nq  = {cur.nq[D1N-2:0], 1'b0};
        end
        // Value root of the square root kind rides along in the first stages.
        vsh = {cur.vrem[VK-1:0], cur.vrad[VN-1:VN-2]};
        vtr = {cur.vroot, 2'b01};
        if (i < VK) begin
          nxt.vrad = cur.vrad << 2;
          if (vsh >= vtr) begin
            nxt.vrem  = vsh - vtr;
            nxt.vroot = {cur.vroot[VK-2:0], 1'b1};
          end else begin
            nxt.vrem  = vsh;
            nxt.vroot = {cur.vroot[VK-2:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) d1_q[i] <= nxt;
      end
    end
  endgenerate

  // Split the wide squares into word-sized partial products.
  always_comb begin
    p3_d.sd     = d1_q[D1N-1].sd;
    p3_d.q1     = d1_q[D1N-1].nq;
    p3_d.vroot  = d1_q[D1N-1].vroot;
    p3_d.addsum = d1_q[D1N-1].addsum;
    p3_d.hh_ba  = W2'(d1_q[D1N-1].pba[W2-1:W]) * W2'(d1_q[D1N-1].pba[W2-1:W]);
    p3_d.hl_ba  = W2'(d1_q[D1N-1].pba[W2-1:W]) * W2'(d1_q[D1N-1].pba[W-1:0]);
    p3_d.ll_ba  = W2'(d1_q[D1N-1].pba[W-1:0])  * W2'(d1_q[D1N-1].pba[W-1:0]);
    p3_d.hh_ab  = W2'(d1_q[D1N-1].pab[W2-1:W]) * W2'(d1_q[D1N-1].pab[W2-1:W]);
    p3_d.hl_ab  = W2'(d1_q[D1N-1].pab[W2-1:W]) * W2'(d1_q[D1N-1].pab[W-1:0]);
    p3_d.ll_ab  = W2'(d1_q[D1N-1].pab[W-1:0])  * W2'(d1_q[D1N-1].pab[W-1:0]);
  end

  always_comb begin
    p4_d.sd     = p3_q.sd;
    p4_d.q1     = p3_q.q1;
    p4_d.vroot  = p3_q.vroot;
    p4_d.addsum = p3_q.addsum;
    p4_d.sq_ba  = (QW'(p3_q.hh_ba) << W2) + (QW'(p3_q.hl_ba) << (W + 1)) + QW'(p3_q.ll_ba);
    p4_d.sq_ab  = (QW'(p3_q.hh_ab) << W2) + (QW'(p3_q.hl_ab) << (W + 1)) + QW'(p3_q.ll_ab);
  end

  // Pick the radicand for the shared root.
  logic [QW-1:0] sq_sum;
  always_comb begin
    sq_sum     = p4_q.sq_ba + p4_q.sq_ab;
    p5_d.sd    = p4_q.sd;
    p5_d.q1    = p4_q.q1;
    p5_d.vroot = p4_q.vroot;
    case (p4_q.sd.kind) inside
      uap_pkg::KIND_ADD,
      uap_pkg::KIND_SUB:  p5_d.rad = RN'(p4_q.addsum);
      uap_pkg::KIND_MUL:  p5_d.rad = RN'(sq_sum);
      uap_pkg::KIND_DIV:  p5_d.rad = RN'(sq_sum) << (2 * F);
      uap_pkg::KIND_SQRT: p5_d.rad = RN'(p4_q.q1);
      default:            p5_d.rad = '0;
    endcase
  end

  always_comb begin
    r_init.sd    = p5_q.sd;
    r_init.q1    = p5_q.q1;
    r_init.vroot = p5_q.vroot;
    r_init.rrad  = p5_q.rad;
    r_init.rrem  = '0;
    r_init.rroot = '0;
  end

  generate
    for (i = 0; i < RK; i++) begin : g_r
      r_t            cur, nxt;
      logic [RK+1:0] sh, tr;
      if (i == 0) begin : g_first
        assign cur = r_init;
      end else begin : g_next
        assign cur = r_q[i-1];
      end
      always_comb begin
        nxt      = cur;
        sh       = {cur.rrem[RK-1:0], cur.rrad[RN-1:RN-2]};
        tr       = {cur.rroot, 2'b01};
        nxt.rrad = cur.rrad << 2;
        if (sh >= tr) begin
          nxt.rrem  = sh - tr;
          nxt.rroot = {cur.rroot[RK-2:0], 1'b1};
        end else begin
          nxt.rrem  = sh;
          nxt.rroot = {cur.rroot[RK-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) r_q[i] <= nxt;
      end
    end
  endgenerate

  // Divide the root by b^2; the quotient needs only a word once overflow is caught.
  d2_t d2_init;
  always_comb begin
    d2_init.sd    = r_q[RK-1].sd;
    d2_init.q1    = r_q[RK-1].q1;
    d2_init.vroot = r_q[RK-1].vroot;
    d2_init.root  = r_q[RK-1].rroot;
    d2_init.ovf   = CW'(r_q[RK-1].rroot >> W) >= CW'(r_q[RK-1].sd.bb);
    d2_init.rem   = D2R'(r_q[RK-1].rroot >> W);
    d2_init.nq    = r_q[RK-1].rroot[W-1:0];
  end

  generate
    for (i = 0; i < W; i++) begin : g_d2
      d2_t            cur, nxt;
      logic [D2R-1:0] sh;
      if (i == 0) begin : g_first
        assign cur = d2_init;
      end else begin : g_next
        assign cur = d2_q[i-1];
      end
      always_comb begin
        nxt = cur;
        sh  = {cur.rem[D2R-2:0], cur.nq[W-1]};
        if (sh >= {1'b0, cur.sd.bb}) begin
          nxt.rem = sh - {1'b0, cur.sd.bb};
          nxt.nq  = {cur.nq[W-2:0], 1'b1};
        end else begin
          nxt.rem = sh;
          nxt.nq  = {cur.nq[W-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) d2_q[i] <= nxt;
      end
    end
  endgenerate

  // Final selection per kind.
  d2_t        fin;
  logic [W:0] u_root, u_rootf, s_mul, s_div;
  logic       v_sat, sat;
  always_comb begin
    fin     = d2_q[W-1];
    u_root  = usat(fin.root);
    u_rootf = usat(fin.root >> F);
    s_mul   = sgn_out(fin.sd.neg, D1N'(fin.sd.pv >> F));
    s_div   = sgn_out(fin.sd.neg, fin.q1);
    v_sat   = XW'(fin.vroot) > XW'(SMAXW);
    rv_d    = '0;
    ru_d    = '0;
    lt_d    = 1'b0;
    eq_d    = 1'b0;
    st_d    = uap_pkg::ST_OK;
    sat     = 1'b0;
    case (fin.sd.kind) inside
      uap_pkg::KIND_ADD,
      uap_pkg::KIND_SUB: begin
        rv_d = fin.sd.rv_e;
        ru_d = u_root[W-1:0];
        sat  = fin.sd.sat_e | u_root[W];
      end
      uap_pkg::KIND_MUL: begin
        rv_d = s_mul[W-1:0];
        ru_d = u_rootf[W-1:0];
        sat  = s_mul[W] | u_rootf[W];
      end
      uap_pkg::KIND_DIV: begin
        if (fin.sd.b_zero) begin
          st_d = uap_pkg::ST_DIVZ;
        end else begin
          rv_d = s_div[W-1:0];
          ru_d = fin.ovf ? {W{1'b1}} : fin.nq;
          sat  = s_div[W] | fin.ovf;
        end
      end
      uap_pkg::KIND_SQRT: begin
        if (fin.sd.a_neg) begin
          st_d = uap_pkg::ST_NEG;
        end else if (fin.sd.a_zero) begin
          ru_d = {W{1'b1}};
          st_d = uap_pkg::ST_DIVZ;
        end else begin
          rv_d = v_sat ? SMAXW : W'(fin.vroot);
          ru_d = u_root[W-1:0];
          sat  = v_sat | u_root[W];
        end
      end
      uap_pkg::KIND_NEG: begin
        rv_d = fin.sd.rv_e;
        ru_d = fin.sd.ua;
        sat  = fin.sd.sat_e;
      end
      uap_pkg::KIND_CMP: begin
        lt_d = fin.sd.lt;
        eq_d = fin.sd.eq;
      end
      default: ;
    endcase
    if (st_d == uap_pkg::ST_OK && sat) st_d = uap_pkg::ST_SAT;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
      p5_q <= p5_d;
      rv_q <= rv_d;
      ru_q <= ru_d;
      lt_q <= lt_d;
      eq_q <= eq_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign result_value_o = rv_q;
  assign result_unc_o   = ru_q;
  assign is_less_o      = lt_q;
  assign is_equal_o     = eq_q;
  assign status_o       = st_q;

endmodule

// File: tb/uncertainty_propagation_alu_unit_test.sv
// Testbench for the uncertainty propagation ALU: directed and random words against a fixed-point predictor.
`timescale 1ns / 1ps

module uncertainty_propagation_alu_unit_test;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int DRAIN_CYCLES = 260;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_WORDS = 1750;

  typedef logic [191:0] wide_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [WB-1:0] a_val;
    logic [WB-1:0] a_unc;
    logic [WB-1:0] b_val;
    logic [WB-1:0] b_unc;
  } operand_word_t;

  typedef struct packed {
    logic [WB-1:0] val;
    logic [WB-1:0] unc;
    logic          lt;
    logic          eq;
    logic [1:0]    st;
  } result_word_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [2:0]    kind = '0;
  logic [WB-1:0] a_value = '0;
  logic [WB-1:0] a_unc = '0;
  logic [WB-1:0] b_value = '0;
  logic [WB-1:0] b_unc = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [WB-1:0] res_value;
  logic [WB-1:0] res_unc;
  logic          res_less;
  logic          res_equal;
  logic [1:0]    res_status;

  operand_word_t pending_words[$];
  result_word_t  expected_results[$];
  bit            in_taken = 1'b0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            quiet_left = 0;
  int            idle_cycles = 0;
  int            error_count = 0;

  uncertainty_propagation_alu_unit #(.FRAC_BITS(FB), .WORD_BITS(WB)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .a_value_i(a_value), .a_unc_i(a_unc),
    .b_value_i(b_value), .b_unc_i(b_unc),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_value_o(res_value), .result_unc_o(res_unc),
    .is_less_o(res_less), .is_equal_o(res_equal), .status_o(res_status)
  );

  always #2 clk = ~clk;

  function automatic wide_t isqrt_floor(wide_t n);
    wide_t r;
    wide_t c;
    r = '0;
    for (int i = 95; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [WB-1:0] clamp_unc(wide_t t, inout bit sat);
    if (t > wide_t'(32'hFFFF_FFFF)) begin
      sat = 1'b1;
      return '1;
    end
    return t[WB-1:0];
  endfunction

  function automatic logic [WB-1:0] clamp_int(longint v, inout bit sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[WB-1:0];
  endfunction

  // Build a signed word from sign and magnitude; the negative side reaches one further.
  function automatic logic [WB-1:0] clamp_signed_mag(bit neg, wide_t m, inout bit sat);
    wide_t lim;
    lim = neg ? wide_t'(33'h8000_0000) : wide_t'(32'h7FFF_FFFF);
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? -m[WB-1:0] : m[WB-1:0];
  endfunction

  function automatic result_word_t propagate_uncertainty(operand_word_t w);
    result_word_t r;
    longint av;
    longint bv;
    wide_t  ma;
    wide_t  mb;
    wide_t  ua;
    wide_t  ub;
    wide_t  t;
    bit     sat;
    bit     neg;
    r = '0;
    sat = 1'b0;
    av = longint'(signed'(w.a_val));
    bv = longint'(signed'(w.b_val));
    ma = wide_t'(av < 0 ? -av : av);
    mb = wide_t'(bv < 0 ? -bv : bv);
    ua = wide_t'(w.a_unc);
    ub = wide_t'(w.b_unc);
    neg = (av < 0) != (bv < 0);
    case (w.kind) inside
      uap_pkg::KIND_ADD, uap_pkg::KIND_SUB: begin
        r.val = clamp_int(w.kind == uap_pkg::KIND_ADD ? av + bv : av - bv, sat);
        r.unc = clamp_unc(isqrt_floor(ua * ua + ub * ub), sat);
      end
      uap_pkg::KIND_MUL: begin
        r.val = clamp_signed_mag(neg, (ma * mb) >> FB, sat);
        t = isqrt_floor((mb * ua) * (mb * ua) + (ma * ub) * (ma * ub)) >> FB;
        r.unc = clamp_unc(t, sat);
      end
      uap_pkg::KIND_DIV: begin
        if (bv == 0) begin
          r.st = uap_pkg::ST_DIVZ;
        end else begin
          r.val = clamp_signed_mag(neg, (ma << FB) / mb, sat);
          t = ((mb * ua) * (mb * ua) + (ma * ub) * (ma * ub)) << (2 * FB);
          r.unc = clamp_unc(isqrt_floor(t) / (mb * mb), sat);
        end
      end
      uap_pkg::KIND_SQRT: begin
        if (av < 0) begin
          r.st = uap_pkg::ST_NEG;
        end else if (av == 0) begin
          r.unc = '1;
          r.st = uap_pkg::ST_DIVZ;
        end else begin
          r.val = clamp_signed_mag(1'b0, isqrt_floor(ma << FB), sat);
          t = ((ua * ua) << FB) / (wide_t'(4) * ma);
          r.unc = clamp_unc(isqrt_floor(t), sat);
        end
      end
      uap_pkg::KIND_NEG: begin
        r.val = clamp_int(-av, sat);
        r.unc = w.a_unc;
      end
      uap_pkg::KIND_CMP: begin
        r.lt = av < bv;
        r.eq = av == bv;
      end
      default: ;
    endcase
    if (r.st == uap_pkg::ST_OK && sat) r.st = uap_pkg::ST_SAT;
    return r;
  endfunction

  function automatic logic [WB-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      3, 4: return $urandom() >>> $urandom_range(8, 24);
      5, 6: return $urandom() | 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WB-1:0] pick_unc();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      1: return $urandom_range(0, 3);
      2, 3, 4: return $urandom() >> $urandom_range(8, 24);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic queue_word(logic [2:0] k, logic [WB-1:0] av, logic [WB-1:0] au,
                            logic [WB-1:0] bv, logic [WB-1:0] bu);
    operand_word_t w;
    w.kind = k;
    w.a_val = av;
    w.a_unc = au;
    w.b_val = bv;
    w.b_unc = bu;
    pending_words.push_back(w);
  endtask

  // Drive the input channel, holding a word until taken, and drive out_ready with random stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (quiet_left > 0) quiet_left <= quiet_left - 1;
      else if ($urandom_range(0, 299) == 0) quiet_left <= $urandom_range(50, 200);
      if (in_valid && !in_taken) begin
      end else if (send_gap > 0 && quiet_left == 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
        operand_word_t w;
        w = pending_words.pop_front();
        kind <= w.kind;
        a_value <= w.a_val;
        a_unc <= w.a_unc;
        b_value <= w.b_val;
        b_unc <= w.b_unc;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
      if (stall_left > 0 && quiet_left == 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Record accepted words and check results against the predictor; a watchdog ends the run when nothing moves.
  always @(posedge clk) begin
    bit fired;
    result_word_t exp_r;
    operand_word_t w;
    fired = 1'b0;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      w.kind = kind;
      w.a_val = a_value;
      w.a_unc = a_unc;
      w.b_val = b_value;
      w.b_unc = b_unc;
      expected_results.push_back(propagate_uncertainty(w));
      fired = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      fired = 1'b1;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected: value %h unc %h", $time,
                 res_value, res_unc);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (res_value !== exp_r.val) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_r.val, res_value);
          error_count++;
        end
        if (res_unc !== exp_r.unc) begin
          $display("%0t: result_unc expected %h actual %h", $time, exp_r.unc, res_unc);
          error_count++;
        end
        if (res_less !== exp_r.lt) begin
          $display("%0t: is_less expected %b actual %b", $time, exp_r.lt, res_less);
          error_count++;
        end
        if (res_equal !== exp_r.eq) begin
          $display("%0t: is_equal expected %b actual %b", $time, exp_r.eq, res_equal);
          error_count++;
        end
        if (res_status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, res_status);
          error_count++;
        end
      end
    end
    if (fired || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int k;
    queue_word(uap_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_word(uap_pkg::KIND_ADD, 32'h0001_0000, 32'h0000_3000, 32'hFFFF_0000, 32'h0000_4000);
    queue_word(uap_pkg::KIND_SUB, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
    queue_word(uap_pkg::KIND_SUB, 32'h0002_8000, 32'h0001_0000, 32'h0001_0000, 32'h0);
    queue_word(uap_pkg::KIND_MUL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_word(uap_pkg::KIND_MUL, 32'h0003_0000, 32'h0000_8000, 32'hFFFE_0000, 32'h0000_4000);
    queue_word(uap_pkg::KIND_MUL, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0);
    queue_word(uap_pkg::KIND_DIV, 32'h0001_0000, 32'h0000_1000, 32'h0, 32'h0000_1000);
    queue_word(uap_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_word(uap_pkg::KIND_DIV, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0);
    queue_word(uap_pkg::KIND_DIV, 32'hFFFA_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_2000);
    queue_word(uap_pkg::KIND_SQRT, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_SQRT, 32'h0, 32'h0000_1000, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_SQRT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_SQRT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_SQRT, 32'h0004_0000, 32'h0000_4000, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_NEG, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(uap_pkg::KIND_NEG, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    queue_word(uap_pkg::KIND_CMP, 32'h0001_0000, 32'h0000_1000, 32'h0001_0000, 32'h0000_2000);
    queue_word(uap_pkg::KIND_CMP, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
    queue_word(uap_pkg::KIND_CMP, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    queue_word(3'd7, 32'h1234_5678, 32'h1, 32'h8765_4321, 32'h2);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      k = $urandom_range(0, 40);
      queue_word(k == 40 ? 3'd7 : 3'(k % 7), pick_value(), pick_unc(), pick_value(),
                 pick_unc());
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
